// ===== src/rmq_pkg.sv =====
// Shared types, branch codes and helpers for the rotation matrix to quaternion core.
`default_nettype none
package rmq_pkg;

  // Matrix entries and quaternion components are 16-bit signed fixed point.
  localparam int unsigned ElemW = 16;
  // One entry sum or difference of two entries.
  localparam int unsigned SumW  = ElemW + 1;
  // Sum of three entries (a candidate for 4q^2-1).
  localparam int unsigned CandW = ElemW + 2;

  localparam logic signed [ElemW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [ElemW-1:0] SatMin = 16'sh8000;

  // Largest component chosen for the branch.
  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } rmq_branch_e;

  typedef struct packed {
    logic signed [ElemW-1:0] m00;
    logic signed [ElemW-1:0] m01;
    logic signed [ElemW-1:0] m02;
    logic signed [ElemW-1:0] m10;
    logic signed [ElemW-1:0] m11;
    logic signed [ElemW-1:0] m12;
    logic signed [ElemW-1:0] m20;
    logic signed [ElemW-1:0] m21;
    logic signed [ElemW-1:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [ElemW-1:0] qx;
    logic signed [ElemW-1:0] qy;
    logic signed [ElemW-1:0] qz;
    logic signed [ElemW-1:0] qw;
    logic [1:0]              branch;
    logic                    clipped;
  } rmq_out_t;

  // Words that ride along the root and reciprocal pipelines: the branch and
  // the three entry sums of the non-chosen components, in x, y, z, w order.
  typedef struct packed {
    rmq_branch_e             br;
    logic signed [SumW-1:0]  s0;
    logic signed [SumW-1:0]  s1;
    logic signed [SumW-1:0]  s2;
  } rmq_side_t;

  // Root width for a given fraction width. The radicand is
  // (best + 2^f) << f, with best < 2^17.
  function automatic int unsigned rmq_root_w(int unsigned f);
    int unsigned rw;
    int unsigned n;
    rw = (f >= 17) ? f + 1 : 18;
    n  = rw + f;
    return (n + 1) >> 1;
  endfunction

  // Saturate an 18-bit signed value to 16 bits; bit 16 of the result flags it.
  function automatic logic [ElemW:0] rmq_sat18(logic signed [ElemW+1:0] v);
    logic [ElemW:0] r;
    if (v > 18'(SatMax)) begin
      r = {1'b1, SatMax};
    end else if (v < 18'(SatMin)) begin
      r = {1'b1, SatMin};
    end else begin
      r = {1'b0, v[ElemW-1:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/rmq_front.sv =====
// Front stages: entry sums, candidates, branch pick and radicand.
`default_nettype none
module rmq_front
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire rmq_in_t                   data_i,
  output logic                           valid_o,
  output logic [2*rmq_root_w(FRAC_BITS)-1:0] rad_o,
  output rmq_side_t                      side_o
);

  localparam int unsigned H  = rmq_root_w(FRAC_BITS);
  localparam int unsigned NE = 2 * H;

  // Stage A: candidates and entry sums
  logic                     a_valid_q;
  logic signed [CandW-1:0]  cand_q [4];
  logic signed [SumW-1:0]   d12_q, d20_q, d01_q, p01_q, p20_q, p12_q;
  logic signed [CandW-1:0]  cand_d [4];

  always_comb begin
    cand_d[0] = CandW'(data_i.m00) + CandW'(data_i.m11) + CandW'(data_i.m22);
    cand_d[1] = CandW'(data_i.m00) - CandW'(data_i.m11) - CandW'(data_i.m22);
    cand_d[2] = CandW'(data_i.m11) - CandW'(data_i.m00) - CandW'(data_i.m22);
    cand_d[3] = CandW'(data_i.m22) - CandW'(data_i.m00) - CandW'(data_i.m11);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cand_q <= cand_d;
      d12_q  <= SumW'(data_i.m12) - SumW'(data_i.m21);
      d20_q  <= SumW'(data_i.m20) - SumW'(data_i.m02);
      d01_q  <= SumW'(data_i.m01) - SumW'(data_i.m10);
      p01_q  <= SumW'(data_i.m01) + SumW'(data_i.m10);
      p20_q  <= SumW'(data_i.m20) + SumW'(data_i.m02);
      p12_q  <= SumW'(data_i.m12) + SumW'(data_i.m21);
    end
  end

  // Stage B: largest candidate, earlier one wins a tie
  logic signed [CandW-1:0] best;
  rmq_branch_e             br;
  rmq_side_t               side_d;
  logic [NE-1:0]           rad_d;

  always_comb begin
    best = cand_q[0];
    br   = BR_W;
    if (cand_q[1] > best) begin
      best = cand_q[1];
      br   = BR_X;
    end
    if (cand_q[2] > best) begin
      best = cand_q[2];
      br   = BR_Y;
    end
    if (cand_q[3] > best) begin
      best = cand_q[3];
      br   = BR_Z;
    end
  end

  // best is never negative: the candidates sum to zero
  always_comb begin
    rad_d = (NE'(best[CandW-2:0]) + (NE'(1) << FRAC_BITS)) << FRAC_BITS;
    side_d.br = br;
    unique case (br)
      BR_W: begin
        side_d.s0 = d12_q;
        side_d.s1 = d20_q;
        side_d.s2 = d01_q;
      end
      BR_X: begin
        side_d.s0 = p01_q;
        side_d.s1 = p20_q;
        side_d.s2 = d12_q;
      end
      BR_Y: begin
        side_d.s0 = p01_q;
        side_d.s1 = p12_q;
        side_d.s2 = d20_q;
      end
      default: begin
        side_d.s0 = p20_q;
        side_d.s1 = p12_q;
        side_d.s2 = d01_q;
      end
    endcase
  end

  logic          b_valid_q;
  logic [NE-1:0] rad_q;
  rmq_side_t     side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = b_valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// ===== src/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmq_sqrt
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic [2*rmq_root_w(FRAC_BITS)-1:0]  rad_i,
  input  wire rmq_side_t                           side_i,
  output logic                                     valid_o,
  output logic [rmq_root_w(FRAC_BITS)-2:0]         big_o,
  output rmq_side_t                                side_o
);

  localparam int unsigned H  = rmq_root_w(FRAC_BITS);
  localparam int unsigned NE = 2 * H;

  logic            valid_q [H];
  logic [H+1:0]    rem_q   [H];
  logic [H-1:0]    root_q  [H];
  logic [NE-1:0]   rad_q   [H];
  rmq_side_t       side_q  [H];

  for (genvar i = 0; i < H; i++) begin : g_step
    logic          v_in;
    logic [H+1:0]  rem_in;
    logic [H-1:0]  root_in;
    logic [NE-1:0] rad_in;
    rmq_side_t     side_in;
    logic [H+1:0]  rem_sh;
    logic [H+1:0]  trial;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign side_in = side_q[i-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_in[H-1:0], rad_in[NE-1 -: 2]};
      trial  = {root_in, 2'b01};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {rad_in[NE-3:0], 2'b00};
        side_q[i] <= side_in;
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[H-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[H-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[H-1];
  assign big_o   = root_q[H-1][H-1:1];
  assign side_o  = side_q[H-1];

  // radicand is at least 2^(2F), so the root is at least 2^F
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[H-1] |-> root_q[H-1] >= (H'(1) << FRAC_BITS))
    else $error("root below lower bound");

endmodule
`default_nettype wire

// ===== src/rmq_div.sv =====
// Pipelined reciprocal: floor(2^(2F-2) / big), one quotient bit per stage.
`default_nettype none
module rmq_div
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic [rmq_root_w(FRAC_BITS)-2:0]    big_i,
  input  wire rmq_side_t                           side_i,
  output logic                                     valid_o,
  output logic [rmq_root_w(FRAC_BITS)-2:0]         big_o,
  output logic [FRAC_BITS-1:0]                     mult_o,
  output rmq_side_t                                side_o
);

  localparam int unsigned BW = rmq_root_w(FRAC_BITS) - 1;
  localparam int unsigned F  = FRAC_BITS;

  // upper dividend bits above the quotient range; below big since big >= 2^(F-1)
  localparam logic [BW:0] Rem0 = (BW+1)'(1) << (F - 2);

  logic            valid_q [F];
  logic [BW:0]     rem_q   [F];
  logic [F-1:0]    quo_q   [F];
  logic [BW-1:0]   big_q   [F];
  rmq_side_t       side_q  [F];

  for (genvar i = 0; i < F; i++) begin : g_step
    logic          v_in;
    logic [BW:0]   rem_in;
    logic [F-1:0]  quo_in;
    logic [BW-1:0] big_in;
    rmq_side_t     side_in;
    logic [BW:0]   rem_sh;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = Rem0;
      assign quo_in  = '0;
      assign big_in  = big_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign big_in  = big_q[i-1];
      assign side_in = side_q[i-1];
    end

    // low dividend bits are all zero
    assign rem_sh = {rem_in[BW-1:0], 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        big_q[i]  <= big_in;
        side_q[i] <= side_in;
        if (rem_sh >= {1'b0, big_in}) begin
          rem_q[i] <= rem_sh - {1'b0, big_in};
          quo_q[i] <= {quo_in[F-2:0], 1'b1};
        end else begin
          rem_q[i] <= rem_sh;
          quo_q[i] <= {quo_in[F-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[F-1];
  assign big_o   = big_q[F-1];
  assign mult_o  = quo_q[F-1];
  assign side_o  = side_q[F-1];

  // big >= 2^(F-1) bounds the multiplier by 2^(F-1)
  a_mult_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[F-1] |-> quo_q[F-1] <= (F'(1) << (F - 1)))
    else $error("multiplier above bound");

endmodule
`default_nettype wire

// ===== src/rmq_scale.sv =====
// Scale stages: sums times multiplier, floor shift, saturation, output register.
`default_nettype none
module rmq_scale
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                valid_i,
  input  wire logic [rmq_root_w(FRAC_BITS)-2:0]    big_i,
  input  wire logic [FRAC_BITS-1:0]                mult_i,
  input  wire rmq_side_t                           side_i,
  output logic                                     valid_o,
  output rmq_out_t                                 data_o
);

  localparam int unsigned BW = rmq_root_w(FRAC_BITS) - 1;
  localparam int unsigned PW = SumW + FRAC_BITS + 1;

  // Stage M: three products
  logic                   m_valid_q;
  logic signed [PW-1:0]   p0_q, p1_q, p2_q;
  logic [BW-1:0]          m_big_q;
  rmq_branch_e            m_br_q;
  logic signed [FRAC_BITS:0] mult_s;

  assign mult_s = $signed({1'b0, mult_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en_i) begin
      m_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q    <= PW'(side_i.s0) * PW'(mult_s);
      p1_q    <= PW'(side_i.s1) * PW'(mult_s);
      p2_q    <= PW'(side_i.s2) * PW'(mult_s);
      m_big_q <= big_i;
      m_br_q  <= side_i.br;
    end
  end

  // Stage S: floor shift by dropping low bits, then saturate
  logic [ElemW:0]          r0, r1, r2, rb;
  rmq_out_t                out_d;

  always_comb begin
    r0 = rmq_sat18(p0_q[PW-1:FRAC_BITS]);
    r1 = rmq_sat18(p1_q[PW-1:FRAC_BITS]);
    r2 = rmq_sat18(p2_q[PW-1:FRAC_BITS]);
    if (m_big_q > BW'(SatMax)) begin
      rb = {1'b1, SatMax};
    end else begin
      rb = {1'b0, ElemW'(m_big_q)};
    end
    out_d.branch  = m_br_q;
    out_d.clipped = r0[ElemW] | r1[ElemW] | r2[ElemW] | rb[ElemW];
    unique case (m_br_q)
      BR_W: begin
        out_d.qx = r0[ElemW-1:0];
        out_d.qy = r1[ElemW-1:0];
        out_d.qz = r2[ElemW-1:0];
        out_d.qw = rb[ElemW-1:0];
      end
      BR_X: begin
        out_d.qx = rb[ElemW-1:0];
        out_d.qy = r0[ElemW-1:0];
        out_d.qz = r1[ElemW-1:0];
        out_d.qw = r2[ElemW-1:0];
      end
      BR_Y: begin
        out_d.qx = r0[ElemW-1:0];
        out_d.qy = rb[ElemW-1:0];
        out_d.qz = r1[ElemW-1:0];
        out_d.qw = r2[ElemW-1:0];
      end
      default: begin
        out_d.qx = r0[ElemW-1:0];
        out_d.qy = r1[ElemW-1:0];
        out_d.qz = rb[ElemW-1:0];
        out_d.qw = r2[ElemW-1:0];
      end
    endcase
  end

  logic     out_valid_q;
  rmq_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/rotation_matrix_to_quaternion_core.sv =====
// Top level: rotation matrix to quaternion, Shepperd branch select, deep pipeline.
//
//  channel  direction  valid        stall         word
//  input    in         in_valid_i   in_stall_o    in_data_i  (nine Q2.14 entries)
//  output   out        out_valid_o  out_stall_i   out_data_o (qx qy qz qw branch clipped)
//
// One word per cycle while the output is not stalled. The stages are two front
// stages, one root bit per stage, one reciprocal bit per stage, a multiply
// stage and the output register.
// Reset clears only the valid bits. A stalled output word freezes every stage,
// and in_stall_o follows it in the same cycle; bubbles are held as well.
`default_nettype none
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire rmq_in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output rmq_out_t      out_data_o,
  input  wire logic     out_stall_i
);

  localparam int unsigned H = rmq_root_w(FRAC_BITS);

  // global advance: everything moves unless a held output word is stalled
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic            f_valid;
  logic [2*H-1:0]  f_rad;
  rmq_side_t       f_side;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (f_valid),
    .rad_o   (f_rad),
    .side_o  (f_side)
  );

  logic            s_valid;
  logic [H-2:0]    s_big;
  rmq_side_t       s_side;

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_valid),
    .big_o   (s_big),
    .side_o  (s_side)
  );

  logic                 d_valid;
  logic [H-2:0]         d_big;
  logic [FRAC_BITS-1:0] d_mult;
  rmq_side_t            d_side;

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .big_i   (s_big),
    .side_i  (s_side),
    .valid_o (d_valid),
    .big_o   (d_big),
    .mult_o  (d_mult),
    .side_o  (d_side)
  );

  rmq_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .big_i   (d_big),
    .mult_i  (d_mult),
    .side_i  (d_side),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // unclipped words carry a chosen component of at least 2^(F-1); checked here for branch W
  a_big_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.clipped && out_data_o.branch == BR_W) |->
      (out_data_o.qw >= $signed(17'(1) << (FRAC_BITS - 1))))
    else $error("chosen component below bound");

endmodule
`default_nettype wire
